[design/tia_pkg.sv]
// shared types, constants and helpers for the task id allocator
package tia_pkg;

  localparam int TASKS   = 256;
  localparam int DEVICES = 1;

  localparam int OP_W    = 2;
  localparam int DEVF_W  = 2;
  localparam int ID_W    = 8;
  localparam int STAT_W  = 3;
  localparam int FCNT_W  = 9;

  localparam int DEV_W     = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int SLOT_W    = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CNT_W     = $clog2(TASKS + 1);
  localparam int MEM_DEPTH = DEVICES * TASKS;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_FREE    = 2'd2,
    OP_DESTROY = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_BADARG = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_NOINIT = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [DEVF_W-1:0] device;
    logic [ID_W-1:0]   task_id;
  } req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [ID_W-1:0]   data;
  } ram_wr_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   granted_id;
    logic [FCNT_W-1:0] free_count;
  } result_t;

  // flat address of one stack slot of one device
  function automatic logic [ADDR_W-1:0] mem_addr(input logic [DEV_W-1:0]  dev,
                                                 input logic [SLOT_W-1:0] slot);
    return ADDR_W'(int'(dev) * TASKS + int'(slot));
  endfunction

endpackage

[design/tia_ram.sv]
// generic single-write, single-read ram with registered read data
module tia_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tia_core.sv]
// per-device pool counters and the decision logic of one operation
module tia_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [tia_pkg::DEVF_W-1:0] lookup_device_i,
  output logic [tia_pkg::ADDR_W-1:0] rd_addr_o,
  input  tia_pkg::req_t         req_i,
  input  logic [tia_pkg::ID_W-1:0]   rd_data_i,
  input  logic                  commit_i,
  output tia_pkg::ram_wr_t      wr_o,
  output tia_pkg::result_t      res_o
);
  import tia_pkg::*;

  logic [CNT_W-1:0] depth_q [DEVICES];
  logic [CNT_W-1:0] depth_d [DEVICES];
  logic [CNT_W-1:0] fresh_q [DEVICES];
  logic [CNT_W-1:0] fresh_d [DEVICES];
  logic             ready_q [DEVICES];
  logic             ready_d [DEVICES];

  logic             lk_ok;
  logic [DEV_W-1:0] lk_idx;
  logic [CNT_W-1:0] lk_depth;
  logic [SLOT_W-1:0] lk_slot;

  // read address of the stack top, from the device being accepted
  always_comb begin
    lk_ok    = {1'b0, lookup_device_i} < 3'(DEVICES);
    lk_idx   = lk_ok ? DEV_W'(lookup_device_i) : '0;
    lk_depth = depth_q[lk_idx];
    lk_slot  = (lk_depth == '0) ? '0 : SLOT_W'(lk_depth - CNT_W'(1));
  end

  assign rd_addr_o = mem_addr(lk_idx, lk_slot);

  logic             dev_ok;
  logic [DEV_W-1:0] idx;
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] fresh;
  logic             ready;
  logic [CNT_W:0]   cnt;

  always_comb begin
    dev_ok = {1'b0, req_i.device} < 3'(DEVICES);
    idx    = dev_ok ? DEV_W'(req_i.device) : '0;
    depth  = depth_q[idx];
    fresh  = fresh_q[idx];
    ready  = ready_q[idx];
    cnt    = (CNT_W+1)'(depth) + (CNT_W+1)'(TASKS) - (CNT_W+1)'(fresh);

    depth_d = depth_q;
    fresh_d = fresh_q;
    ready_d = ready_q;

    wr_o.en   = 1'b0;
    wr_o.addr = mem_addr(idx, SLOT_W'(depth));
    wr_o.data = req_i.task_id;

    res_o.status     = ST_OK;
    res_o.granted_id = '0;
    res_o.free_count = '0;

    if (!dev_ok) begin
      res_o.status = ST_BADARG;
    end else begin
      case (req_i.op)
        OP_INIT: begin
          depth_d[idx] = '0;
          fresh_d[idx] = '0;
          ready_d[idx] = 1'b1;
          res_o.free_count = FCNT_W'(TASKS);
        end
        OP_ALLOC: begin
          if (!ready) begin
            res_o.status = ST_NOINIT;
          end else if (cnt == '0) begin
            res_o.status = ST_EMPTY;
          end else begin
            res_o.free_count = FCNT_W'(cnt - (CNT_W+1)'(1));
            if (depth != '0) begin
              // pop a returned id
              depth_d[idx]     = depth - CNT_W'(1);
              res_o.granted_id = rd_data_i;
            end else begin
              fresh_d[idx]     = fresh + CNT_W'(1);
              res_o.granted_id = ID_W'(fresh);
            end
          end
        end
        OP_FREE: begin
          res_o.free_count = FCNT_W'(cnt);
          if (32'(req_i.task_id) >= 32'(TASKS)) begin
            res_o.status = ST_BADARG;
          end else if (!ready) begin
            res_o.status = ST_NOINIT;
          end else if (cnt >= (CNT_W+1)'(TASKS) || 32'(depth) >= 32'(TASKS)) begin
            res_o.status = ST_FULL;
          end else begin
            wr_o.en          = commit_i;
            depth_d[idx]     = depth + CNT_W'(1);
            res_o.free_count = FCNT_W'(cnt + (CNT_W+1)'(1));
          end
        end
        default: begin
          // destroy
          if (!ready) begin
            res_o.status = ST_NOINIT;
          end else begin
            depth_d[idx] = '0;
            fresh_d[idx] = CNT_W'(TASKS);
            ready_d[idx] = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < DEVICES; d++) begin
        depth_q[d] <= '0;
        fresh_q[d] <= CNT_W'(TASKS);
        ready_q[d] <= 1'b0;
      end
    end else if (commit_i) begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
      ready_q <= ready_d;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q[0]) <= 32'(TASKS))
    else $error("returned stack depth beyond pool size");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fresh_q[0]) <= 32'(TASKS))
    else $error("fresh id pointer beyond pool size");

endmodule

[design/task_id_allocator.sv]
// task id allocator top level: handshake, operation sequencing and id stack ram
//
// Each device owns a pool of task ids 0..TASKS-1. Init refills the pool, allocate
// hands out the head (most recently freed ids first, then untouched ids in
// ascending order), free pushes an id back on the head and destroy empties the
// pool. Every operation returns exactly one result with a status, the granted id
// and the free count after the operation. In the accept cycle the top of the
// device's returned-id stack is read from the single-port-read stack ram; in the
// execute state the result is computed, and once the output register is empty
// or being drained the counters are updated and a free writes its id into the
// ram. No new operation is accepted until the current one has completed; a
// result waiting in the output register does not block the next transfer in,
// only its completion. The stack ram needs no clearing after reset, since a
// slot is read only after a free has written it.
module task_id_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tia_pkg::OP_W-1:0]    operation_i,
  input  logic [tia_pkg::DEVF_W-1:0]  device_i,
  input  logic [tia_pkg::ID_W-1:0]    task_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tia_pkg::STAT_W-1:0]  status_o,
  output logic [tia_pkg::ID_W-1:0]    granted_id_o,
  output logic [tia_pkg::FCNT_W-1:0]  free_count_o
);
  import tia_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e           state_q;
  req_t             req_q;
  logic             out_valid_q;
  result_t          out_q;

  logic             in_xfer;
  logic             exec_go;
  logic [ADDR_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_data;
  ram_wr_t          ram_wr;
  result_t          res;

  // new transfer only between operations
  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  // finish when the output register is empty or being drained
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.op      <= op_e'(operation_i);
      req_q.device  <= device_i;
      req_q.task_id <= task_id_i;
    end
    if (exec_go) begin
      out_q <= res;
    end
  end

  tia_ram #(
    .Width(ID_W),
    .Depth(MEM_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_wr.en),
    .waddr_i(ram_wr.addr),
    .wdata_i(ram_wr.data),
    .re_i   (in_xfer),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  tia_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lookup_device_i(device_i),
    .rd_addr_o      (rd_addr),
    .req_i          (req_q),
    .rd_data_i      (rd_data),
    .commit_i       (exec_go),
    .wr_o           (ram_wr),
    .res_o          (res)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign granted_id_o = out_q.granted_id;
  assign free_count_o = out_q.free_count;

  a_wr_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.en |-> exec_go)
    else $error("stack write outside operation commit");

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_EXEC))
    else $error("accepted operation not executed next cycle");

  a_commit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (out_valid_q && state_q == S_IDLE))
    else $error("committed operation did not produce a result");

endmodule
